// ----- rtl/mersenne_twister_generator_core_macros.svh -----
// ----------------------------------------------------------------------------
// MT19937 generator assertion macros
// Concurrent assertion forms for the generator port checker.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_CORE_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, off while reset is low
`define MTG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define MTG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always checked
`define MTG_ASSERT_NXT_ALL(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mtg_pkg.sv -----
// ----------------------------------------------------------------------------
// MT19937 generator package
// Sizes, constants, command codes and tempering shared by the generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int unsigned WORD_COUNT = 624;
    localparam int unsigned SHIFT_DIST = 397;
    localparam int unsigned WRAP_DIST  = WORD_COUNT - SHIFT_DIST;
    localparam int unsigned ADDR_W     = $clog2(WORD_COUNT + 1);

    typedef logic [31:0]       t_word;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_word INIT_MULT    = 32'h6c07_8965;
    localparam t_word MATRIX_A     = 32'h9908_b0df;
    localparam t_word TEMPER_B     = 32'h9d2c_5680;
    localparam t_word TEMPER_C     = 32'hefc6_0000;
    localparam t_word DEFAULT_SEED = 32'd5489;

    localparam t_addr LAST_ADDR = t_addr'(WORD_COUNT - 1);
    localparam t_addr END_ADDR  = t_addr'(WORD_COUNT);
    localparam t_addr WRAP_ADDR = t_addr'(WRAP_DIST);
    localparam t_addr SHIFT_OFS = t_addr'(SHIFT_DIST);

    typedef enum logic {
        CMD_SEED = 1'b0,
        CMD_DRAW = 1'b1
    } t_kind;

    typedef struct packed {
        logic  kind;
        t_word seed_value;
    } t_cmd;

    function automatic t_word temper(input t_word w);
        t_word a;
        t_word b;
        t_word c;
        a = w ^ (w >> 11);
        b = a ^ ((a << 7) & TEMPER_B);
        c = b ^ ((b << 15) & TEMPER_C);
        return c ^ (c >> 18);
    endfunction

endpackage

// ----- rtl/mtg_if.sv -----
// ----------------------------------------------------------------------------
// MT19937 generator channels
// Valid/ready command channel and result channel.
// ----------------------------------------------------------------------------
interface mtg_cmd_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] seed_value;

    modport source (output valid, output kind, output seed_value, input ready);
    modport sink   (input valid, input kind, input seed_value, output ready);
endinterface

interface mtg_rand_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

// ----- rtl/mtg_front.sv -----
// ----------------------------------------------------------------------------
// MT19937 generator front end
// Accepts command words and queues them, two deep, for the engine.
// ----------------------------------------------------------------------------
module mtg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mtg_cmd_if.sink       i_cmd,
    mtg_cmd_if.source     o_cmd
);
    import mtg_pkg::*;

    t_cmd       r_data [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign i_cmd.ready      = (r_cnt != 2'd2);
    assign push             = i_cmd.valid && i_cmd.ready;
    assign pop              = o_cmd.valid && o_cmd.ready;
    assign o_cmd.valid      = (r_cnt != 2'd0);
    assign o_cmd.kind       = r_data[r_rd].kind;
    assign o_cmd.seed_value = r_data[r_rd].seed_value;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wr].kind       <= i_cmd.kind;
            r_data[r_wr].seed_value <= (i_cmd.kind == CMD_SEED) ? i_cmd.seed_value : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- rtl/mtg_back.sv -----
// ----------------------------------------------------------------------------
// MT19937 generator engine
// Holds the state memory, seeds it and twists one word per draw.
// ----------------------------------------------------------------------------
module mtg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mtg_cmd_if.sink       i_cmd,
    mtg_rand_if.source    o_rand
);
    import mtg_pkg::*;

    typedef enum logic [3:0] {
        S_SINIT,
        S_IDLE,
        S_SMUL,
        S_SADD,
        S_RD0,
        S_RD1,
        S_RD2,
        S_TW,
        S_OUT
    } t_state;

    t_word  mem [WORD_COUNT];

    t_state r_state;
    t_addr  r_pos;
    t_addr  r_idx;
    t_word  r_prev;
    t_word  r_prod;
    t_word  r_rdata;
    logic   r_hi;
    logic [30:0] r_lo;
    t_word  r_word;
    logic   r_out_valid;
    t_word  r_out_word;

    t_addr  next_addr;
    t_addr  far_addr;
    t_addr  rd_addr;
    logic   mem_we;
    t_addr  mem_wa;
    t_word  mem_wd;
    t_word  seed_word;
    t_word  joined;
    t_word  twisted;

    assign next_addr = (r_pos == LAST_ADDR) ? '0 : t_addr'(r_pos + 1'b1);
    assign far_addr  = (r_pos >= WRAP_ADDR) ? t_addr'(r_pos - WRAP_ADDR)
                                            : t_addr'(r_pos + SHIFT_OFS);
    assign seed_word = r_prod + {{(32-ADDR_W){1'b0}}, r_idx};
    assign joined    = {r_hi, r_lo};
    assign twisted   = r_rdata ^ (joined >> 1) ^ (joined[0] ? MATRIX_A : '0);

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_rand.valid       = r_out_valid;
    assign o_rand.random_word = r_out_word;

    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_pos;
        mem_wd  = twisted;
        rd_addr = r_pos;
        unique case (r_state)
            S_SINIT: begin
                mem_we = 1'b1;
                mem_wa = '0;
                mem_wd = DEFAULT_SEED;
            end
            S_IDLE: begin
                mem_we = i_cmd.valid && (i_cmd.kind == CMD_SEED);
                mem_wa = '0;
                mem_wd = i_cmd.seed_value;
            end
            S_SADD: begin
                mem_we = 1'b1;
                mem_wa = r_idx;
                mem_wd = seed_word;
            end
            S_RD1:   rd_addr = next_addr;
            S_RD2:   rd_addr = far_addr;
            S_TW:    mem_we  = 1'b1;
            default: mem_we  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SINIT;
            r_pos       <= END_ADDR;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rand.valid && o_rand.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_SINIT: begin
                    r_prev  <= DEFAULT_SEED;
                    r_idx   <= t_addr'(1);
                    r_state <= S_SMUL;
                end
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        if (i_cmd.kind == CMD_SEED) begin
                            r_prev  <= i_cmd.seed_value;
                            r_idx   <= t_addr'(1);
                            r_state <= S_SMUL;
                        end else begin
                            if (r_pos >= END_ADDR) r_pos <= '0;
                            r_state <= S_RD0;
                        end
                    end
                end
                S_SMUL: begin
                    r_prod  <= INIT_MULT * (r_prev ^ (r_prev >> 30));
                    r_state <= S_SADD;
                end
                S_SADD: begin
                    r_prev <= seed_word;
                    if (r_idx == LAST_ADDR) begin
                        r_pos   <= END_ADDR;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= t_addr'(r_idx + 1'b1);
                        r_state <= S_SMUL;
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_hi    <= r_rdata[31];
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_lo    <= r_rdata[30:0];
                    r_state <= S_TW;
                end
                S_TW: begin
                    r_word  <= twisted;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_word  <= temper(r_word);
                        r_out_valid <= 1'b1;
                        r_pos       <= t_addr'(r_pos + 1'b1);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/mersenne_twister_generator_core.sv -----
// ----------------------------------------------------------------------------
// MT19937 generator core
// 32-bit Mersenne Twister with seed and draw commands.
//
//   channel   dir   payload                 transfer
//   i_cmd     in    kind, seed_value        valid & ready
//   o_rand    out   random_word             valid & ready
//
// A draw makes three reads of the state memory, the twist write of one
// word, and puts the tempered result into the output register.
// A seed writes one state word at a time through the registered
// multiplier. After reset the same sequence seeds from 5489, so
// commands are queued (two deep) but not executed until it is done.
// A stalled result holds the next draw; the queue takes up to two commands.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mtg_cmd_if.sink       i_cmd,
    mtg_rand_if.source    o_rand
);

    mtg_cmd_if u_queue_if ();

    mtg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_cmd   (u_queue_if)
    );

    mtg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (u_queue_if),
        .o_rand  (o_rand)
    );

endmodule

// ----- rtl/mtg_checker.sv -----
// ----------------------------------------------------------------------------
// MT19937 generator port checker
// Watches the result channel of the generator core over time.
// ----------------------------------------------------------------------------
`include "mersenne_twister_generator_core_macros.svh"

module mtg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word
);

    `MTG_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word), "stalled result word changed or dropped")
    `MTG_ASSERT_NXT_ALL(a_rst_clear, i_clk, !i_rst_n, !i_out_valid, "result valid right after reset")
    `MTG_ASSERT_NXT(a_no_b2b, i_clk, i_rst_n, i_out_valid && i_out_ready, !i_out_valid, "result words delivered in consecutive cycles")
    `MTG_ASSERT_IMP(a_rise_gap, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_out_valid), "result valid rose without a gap")

endmodule

bind mersenne_twister_generator_core mtg_checker u_mtg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rand.valid),
    .i_out_ready (o_rand.ready),
    .i_out_word  (o_rand.random_word)
);

// ----- tb/sv/mtg_word_checker.sv -----
// ----------------------------------------------------------------------------
// MT19937 generator word checker
// Watches the command and result channels, keeps its own copy of the
// 624-word generator state, predicts each tempered draw word and compares
// it with the word that the core delivers, in order.
// ----------------------------------------------------------------------------
module mtg_word_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mtg_cmd_if    i_cmd,
    mtg_rand_if   i_rand,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_seeds,
    output int    o_draws,
    output int    o_twists
);
    import mtg_pkg::*;

    t_word       gen_state [0:WORD_COUNT-1];
    t_addr       gen_pos;
    t_word       pending_words [$];
    int          fail_count;
    int          seed_count;
    int          draw_count;
    int          twist_count;

    function automatic void seed_state(input t_word s);
        t_word prev;
        gen_state[0] = s;
        for (t_addr k = t_addr'(1); k < END_ADDR; k++) begin
            prev = gen_state[t_addr'(k - 1'b1)];
            gen_state[k] = INIT_MULT * (prev ^ (prev >> 30)) + t_word'(k);
        end
        gen_pos = END_ADDR;
    endfunction

    function automatic void twist_state();
        t_word joined;
        t_word mixed;
        t_addr kn;
        t_addr kf;
        for (t_addr k = '0; k < END_ADDR; k++) begin
            kn = (k == LAST_ADDR) ? '0 : t_addr'(k + 1'b1);
            kf = (k >= WRAP_ADDR) ? t_addr'(k - WRAP_ADDR) : t_addr'(k + SHIFT_OFS);
            joined = {gen_state[k][31], gen_state[kn][30:0]};
            mixed  = joined >> 1;
            if (joined[0]) begin
                mixed = mixed ^ MATRIX_A;
            end
            gen_state[k] = gen_state[kf] ^ mixed;
        end
    endfunction

    function automatic t_word temper_word(input t_word w);
        t_word y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        return y ^ (y >> 18);
    endfunction

    function automatic t_word draw_word();
        t_word w;
        if (gen_pos >= END_ADDR) begin
            twist_state();
            gen_pos = '0;
            twist_count++;
        end
        w = gen_state[gen_pos];
        gen_pos = t_addr'(gen_pos + 1'b1);
        return temper_word(w);
    endfunction

    initial begin
        fail_count  = 0;
        seed_count  = 0;
        draw_count  = 0;
        twist_count = 0;
    end

    always @(posedge i_clk) begin
        t_word want;
        if (!i_rst_n) begin
            seed_state(DEFAULT_SEED);
            pending_words.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                if (t_kind'(i_cmd.kind) == CMD_SEED) begin
                    seed_state(i_cmd.seed_value);
                    seed_count++;
                end else begin
                    pending_words.insert(pending_words.size(), draw_word());
                end
            end
            if (i_rand.valid && i_rand.ready) begin
                draw_count++;
                if (pending_words.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none, actual %08h",
                             $time, i_rand.random_word);
                end else begin
                    want = pending_words.pop_front();
                    if (i_rand.random_word !== want) begin
                        fail_count++;
                        $display("%0t: random_word mismatch, expected %08h, actual %08h",
                                 $time, want, i_rand.random_word);
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_words.size();
        o_seeds      <= seed_count;
        o_draws      <= draw_count;
        o_twists     <= twist_count;
    end

endmodule

// ----- tb/sv/tb_mersenne_twister_generator_core.sv -----
// ----------------------------------------------------------------------------
// MT19937 generator core testbench
// Sends directed and random seed and draw words in bursts while the result
// side stalls on changing patterns; a side checker predicts every draw and
// counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_generator_core;
    import mtg_pkg::*;

    localparam int ITEM_TARGET = 1350;
    localparam int IDLE_LIMIT  = 8000;
    localparam int DRAIN_WAIT  = 1300;

    logic i_clk;
    logic i_rst_n;

    mtg_cmd_if  cmd_ch ();
    mtg_rand_if rand_ch ();

    int fail_count;
    int pending;
    int seeds_seen;
    int draws_seen;
    int twists_seen;
    int sent;
    int burst_left;
    int idle_cycles;

    mersenne_twister_generator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rand  (rand_ch)
    );

    mtg_word_checker u_word_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_rand       (rand_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_seeds      (seeds_seen),
        .o_draws      (draws_seen),
        .o_twists     (twists_seen)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send_word(input t_kind k, input t_word s);
        if (burst_left == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.kind       <= k;
        cmd_ch.seed_value <= s;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        burst_left--;
        sent++;
    endtask

    // result side: pick a new 8-bit ready mask whenever the slot count runs out and step through its bits
    initial begin
        logic [7:0] mask;
        int         slot;
        int         pick;
        rand_ch.ready <= 1'b0;
        slot = 0;
        mask = 8'hFF;
        forever begin
            @(posedge i_clk);
            if (slot == 0) begin
                pick = $urandom_range(0, 5);
                if (pick < 2) begin
                    mask = 8'hFF;
                end else if (pick == 2) begin
                    mask = 8'h00;
                end else begin
                    mask = 8'($urandom);
                end
                slot = 32;
            end
            slot--;
            rand_ch.ready <= mask[3'(slot)];
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (rand_ch.valid && rand_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_word corner_seeds [4];
        t_word seed;
        int    pick;
        int    n_draws;
        bit    first_run;
        corner_seeds = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
        sent        = 0;
        burst_left  = 0;
        idle_cycles = 0;
        first_run   = 1'b1;
        i_rst_n           <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.kind       <= CMD_DRAW;
        cmd_ch.seed_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(CMD_DRAW, 32'h0000_0000);
        send_word(CMD_DRAW, 32'hFFFF_FFFF);
        send_word(CMD_DRAW, 32'hA5A5_A5A5);
        send_word(CMD_SEED, 32'h0000_0000);
        send_word(CMD_DRAW, 32'h5A5A_5A5A);
        send_word(CMD_DRAW, 32'h0000_0000);
        send_word(CMD_SEED, 32'hFFFF_FFFF);
        send_word(CMD_DRAW, 32'hFFFF_FFFF);
        send_word(CMD_DRAW, 32'h1234_5678);
        send_word(CMD_SEED, 32'h0000_0001);
        send_word(CMD_SEED, 32'h8000_0000);
        send_word(CMD_DRAW, 32'h0000_0000);
        send_word(CMD_DRAW, 32'hFFFF_FFFF);
        send_word(CMD_SEED, 32'h5555_5555);
        send_word(CMD_SEED, 32'hAAAA_AAAA);
        send_word(CMD_DRAW, 32'h8000_0001);
        send_word(CMD_SEED, DEFAULT_SEED);
        send_word(CMD_DRAW, 32'h7FFF_FFFE);

        while (sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                send_word(CMD_SEED, $urandom);
                send_word(CMD_SEED, $urandom);
            end else if (pick != 1) begin
                seed = ($urandom_range(0, 7) == 0) ? corner_seeds[2'($urandom_range(0, 3))]
                                                   : t_word'($urandom);
                send_word(CMD_SEED, seed);
            end
            if (first_run || $urandom_range(0, 4) == 0) begin
                n_draws = $urandom_range(625, 700);
            end else begin
                n_draws = $urandom_range(0, 30);
            end
            if (sent + n_draws > ITEM_TARGET) begin
                n_draws = (sent < ITEM_TARGET) ? ITEM_TARGET - sent : 0;
            end
            first_run = 1'b0;
            repeat (n_draws) send_word(CMD_DRAW, $urandom);
        end
        cmd_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d command words: %0d seeds, %0d draw words checked, %0d state twists",
                 sent, seeds_seen, draws_seen, twists_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
